>>> hw/rtl/sisl_pkg.sv
// ----------------------------------------------------------------------------
// sisl_pkg
// Shared constants, types and codes for the sorted insertion list block.
// ----------------------------------------------------------------------------
package sisl_pkg;

	localparam int LIST_DEPTH  = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int POS_W       = $clog2(LIST_DEPTH);
	localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
	localparam int OPC_W       = 2;

	typedef logic signed [VALUE_WIDTH-1:0] elem_t;
	typedef logic [POS_W-1:0]              pos_t;
	typedef logic [CNT_W-1:0]              cnt_t;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_COPY   = 2'd1,
		OP_SHOW   = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic do_insert;
		logic do_copy;
		logic start_run;
		logic sel_snap;
		logic refused;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic main_full;
		logic run_last;
		logic out_free;
	} dp_sts_t;

endpackage

>>> hw/rtl/sisl_ctrl.sv
// ----------------------------------------------------------------------------
// sisl_ctrl
// Sequencer: takes one request at a time, issues list updates and steps the
// result run one entry per cycle while the output is free.
// ----------------------------------------------------------------------------
module sisl_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [sisl_pkg::OPC_W-1:0] opcode,
	input  sisl_pkg::dp_sts_t          sts,
	output sisl_pkg::dp_cmd_t          cmd
);
	import sisl_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (opcode)
						OP_INSERT: begin
							cmd.do_insert = !sts.main_full;
							cmd.refused   = sts.main_full;
							cmd.start_run = 1'b1;
							state_d       = ST_EMIT;
						end
						OP_COPY: begin
							cmd.do_copy = 1'b1;
						end
						OP_SHOW: begin
							cmd.sel_snap  = 1'b1;
							cmd.start_run = 1'b1;
							state_d       = ST_EMIT;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.step = 1'b1;
					if (sts.run_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/sisl_dp.sv
// ----------------------------------------------------------------------------
// sisl_dp
// Datapath: sorted list with parallel compare-and-shift insert, snapshot
// copy, run index and output register.
// ----------------------------------------------------------------------------
module sisl_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sisl_pkg::elem_t             value,
	input  sisl_pkg::dp_cmd_t           cmd,
	output sisl_pkg::dp_sts_t           sts,
	output logic                        out_valid,
	input  logic                        out_stall,
	output sisl_pkg::elem_t             element,
	output logic [sisl_pkg::POS_W-1:0]  position,
	output logic                        last,
	output logic [sisl_pkg::CNT_W-1:0]  entry_count,
	output logic                        list_empty,
	output logic                        insert_refused
);
	import sisl_pkg::*;

	elem_t main_q [LIST_DEPTH];
	elem_t snap_q [LIST_DEPTH];
	cnt_t  main_cnt_q;
	cnt_t  snap_cnt_q;
	pos_t  idx_q;
	logic  sel_snap_q;
	logic  refused_q;
	logic  out_valid_q;

	logic [LIST_DEPTH-1:0] gt;
	cnt_t                  run_cnt;
	elem_t                 run_elem;
	logic                  run_empty;
	logic                  run_last;

	always_comb begin
		for (int k = 0; k < LIST_DEPTH; k++) begin
			gt[k] = (cnt_t'(k) < main_cnt_q) && (main_q[k] > value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_insert) begin
			for (int k = 0; k < LIST_DEPTH; k++) begin
				if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
					main_q[k] <= main_q[(k > 0) ? k - 1 : 0];
				end else if (gt[k] || cnt_t'(k) == main_cnt_q) begin
					main_q[k] <= value;
				end
			end
		end
		if (cmd.do_copy) begin
			for (int k = 0; k < LIST_DEPTH; k++) begin
				snap_q[k] <= main_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_cnt_q <= '0;
			snap_cnt_q <= '0;
		end else begin
			if (cmd.do_insert) begin
				main_cnt_q <= main_cnt_q + cnt_t'(1);
			end
			if (cmd.do_copy) begin
				snap_cnt_q <= main_cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			sel_snap_q <= 1'b0;
			refused_q  <= 1'b0;
		end else if (cmd.start_run) begin
			idx_q      <= '0;
			sel_snap_q <= cmd.sel_snap;
			refused_q  <= cmd.refused;
		end else if (cmd.step) begin
			idx_q <= idx_q + pos_t'(1);
		end
	end

	assign run_cnt   = sel_snap_q ? snap_cnt_q : main_cnt_q;
	assign run_elem  = sel_snap_q ? snap_q[idx_q] : main_q[idx_q];
	assign run_empty = (run_cnt == '0);
	assign run_last  = run_empty || ((cnt_t'(idx_q) + cnt_t'(1)) == run_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			element        <= run_empty ? elem_t'(0) : run_elem;
			position       <= idx_q;
			last           <= run_last;
			entry_count    <= run_cnt;
			list_empty     <= run_empty;
			insert_refused <= refused_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.main_full = (main_cnt_q == cnt_t'(LIST_DEPTH));
	assign sts.run_last  = run_last;
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

>>> hw/rtl/sorted_insert_list_with_snapshot_core.sv
// ----------------------------------------------------------------------------
// sorted_insert_list_with_snapshot_core
// Sorted insertion list with snapshot copy: inserts keep ascending order,
// insert and show requests return the list as a run of results.
// ----------------------------------------------------------------------------
// The first result passes the state register, then the output register.
// New requests wait until a run of N results (N = entries shown, at least
// 1) ends, one entry per cycle from the single read port unless stalled.
// Reset clears both entry counts; stored entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_list_with_snapshot_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sisl_pkg::OPC_W-1:0]  opcode,
	input  sisl_pkg::elem_t             value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output sisl_pkg::elem_t             element,
	output logic [sisl_pkg::POS_W-1:0]  position,
	output logic                        last,
	output logic [sisl_pkg::CNT_W-1:0]  entry_count,
	output logic                        list_empty,
	output logic                        insert_refused
);
	import sisl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	sisl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	sisl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.value          (value),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.element        (element),
		.position       (position),
		.last           (last),
		.entry_count    (entry_count),
		.list_empty     (list_empty),
		.insert_refused (insert_refused)
	);

endmodule
